// File: hdl/vrpts_pkg.sv
// ----------------------------------------------------------------------------
// vrpts_pkg
// Widths, codes and types shared by the vector rotate, pop and search block.
// ----------------------------------------------------------------------------
package vrpts_pkg;

  localparam int unsigned DEPTH   = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FOUND_W = 6;

  localparam logic signed [FOUND_W-1:0] FOUND_NONE = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_ROT_RIGHT = 3'd1,
    ACT_ROT_LEFT  = 3'd2,
    ACT_POP       = 3'd3,
    ACT_SEARCH    = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_MISS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_NEXT,
    CELL_FROM_PREV,
    CELL_FROM_HEAD
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_ROT,
    S_SCAN
  } state_e;

endpackage

// File: hdl/vector_rotate_pop_transpose_search.sv
// ----------------------------------------------------------------------------
// vector_rotate_pop_transpose_search
// Bounded vector of signed entries with append, rotation, pop and
// transposition search, held in a row of neighbour-linked cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i / in_ready_o action, value, position, steps
//  out      output     out_valid_o/out_ready_i status, data, found_index, count
//
// Append, rotate left, pop and unused codes finish in the cycle of the transfer;
// their result shows in the next cycle. Rotate right on two or more entries
// forms steps mod count serially, shifts the row left one place a cycle (up to
// count - 1 times) and loads the result. Search walks the row one cell a cycle,
// up to count. A new item is taken only when idle with the result register free
// or draining. Reset empties the vector; entries are not cleared.
// ----------------------------------------------------------------------------
module vector_rotate_pop_transpose_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [vrpts_pkg::ACT_W-1:0]          action_i,
  input  logic signed [vrpts_pkg::DATA_W-1:0]  value_i,
  input  logic [vrpts_pkg::POS_W-1:0]          position_i,
  input  logic [vrpts_pkg::STEPS_W-1:0]        steps_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [vrpts_pkg::STAT_W-1:0]         status_o,
  output logic signed [vrpts_pkg::DATA_W-1:0]  data_o,
  output logic signed [vrpts_pkg::FOUND_W-1:0] found_index_o,
  output logic [vrpts_pkg::CNT_W-1:0]          count_o
);
  import vrpts_pkg::*;

  state_e state_d, state_q;

  logic [CNT_W-1:0]         count_d, count_q;
  logic [IDX_W-1:0]         rot_d, rot_q;
  logic [IDX_W-1:0]         scan_d, scan_q;
  logic signed [DATA_W-1:0] value_d, value_q;

  logic                      out_valid_d, out_valid_q;
  logic [STAT_W-1:0]         status_q;
  logic signed [DATA_W-1:0]  data_q;
  logic signed [FOUND_W-1:0] found_q;
  logic [CNT_W-1:0]          out_count_q;

  logic                      res_load;
  status_e                   res_status;
  logic signed [DATA_W-1:0]  res_data;
  logic signed [FOUND_W-1:0] res_found;
  logic [CNT_W-1:0]          res_count;

  logic do_append, do_left, do_pop, do_swap;
  logic mod_start, mod_done;
  logic [IDX_W-1:0] mod_rem;

  logic can_out, accept, hit, last;

  logic signed [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]         match;
  cell_op_e                 cell_op [DEPTH];
  logic signed [DATA_W-1:0] cell_value;
  logic signed [DATA_W-1:0] pop_data;

  assign can_out    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_out;
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = match[scan_q];
  assign last       = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
  assign cell_value = (state_q == S_IDLE) ? value_i : value_q;
  assign pop_data   = entry[position_i];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_ROT_RIGHT && count_q > CNT_W'(1)) begin
            state_d = S_MOD;
          end else if (action_i == ACT_SEARCH && count_q != '0) begin
            state_d = S_SCAN;
          end
        end
      end
      S_MOD: begin
        if (mod_done) state_d = S_ROT;
      end
      S_ROT: begin
        if (rot_q == '0 && can_out) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (can_out && (hit || last)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controls and result
  always_comb begin
    do_append  = 1'b0;
    do_left    = 1'b0;
    do_pop     = 1'b0;
    do_swap    = 1'b0;
    mod_start  = 1'b0;
    count_d    = count_q;
    rot_d      = rot_q;
    scan_d     = scan_q;
    value_d    = value_q;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_data   = '0;
    res_found  = FOUND_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          value_d  = value_i;
          res_load = 1'b1;
          unique case (action_i)
            ACT_APPEND: begin
              if (count_q < CNT_W'(DEPTH)) begin
                do_append = 1'b1;
                count_d   = count_q + CNT_W'(1);
              end else begin
                res_status = STAT_FULL;
              end
            end
            ACT_ROT_RIGHT: begin
              if (count_q > CNT_W'(1)) begin
                mod_start = 1'b1;
                res_load  = 1'b0;
              end
            end
            ACT_ROT_LEFT: begin
              if (count_q > CNT_W'(1)) do_left = 1'b1;
            end
            ACT_POP: begin
              if (CNT_W'(position_i) >= count_q) begin
                res_status = STAT_BAD;
              end else begin
                do_pop   = 1'b1;
                res_data = pop_data;
                count_d  = count_q - CNT_W'(1);
              end
            end
            ACT_SEARCH: begin
              if (count_q == '0) begin
                res_status = STAT_MISS;
              end else begin
                scan_d   = '0;
                res_load = 1'b0;
              end
            end
            default: res_status = STAT_BAD;
          endcase
        end
      end
      S_MOD: begin
        // A right rotation by r equals a left rotation by count - r.
        if (mod_done) begin
          if (mod_rem == '0) begin
            rot_d = '0;
          end else begin
            rot_d = IDX_W'(count_q - CNT_W'(mod_rem));
          end
        end
      end
      S_ROT: begin
        if (rot_q != '0) begin
          do_left = 1'b1;
          rot_d   = rot_q - IDX_W'(1);
        end else if (can_out) begin
          res_load = 1'b1;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (can_out) begin
            res_load = 1'b1;
            if (scan_q != '0) begin
              do_swap   = 1'b1;
              res_found = FOUND_W'(scan_q - IDX_W'(1));
            end else begin
              res_found = '0;
            end
          end
        end else if (last) begin
          if (can_out) begin
            res_load   = 1'b1;
            res_status = STAT_MISS;
          end
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
    res_count   = count_d;
    out_valid_d = res_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Per-cell operation decode
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (do_append && CNT_W'(i) == count_q) begin
        cell_op[i] = CELL_LOAD;
      end
      if (do_left) begin
        if (CNT_W'(i + 1) < count_q) begin
          cell_op[i] = CELL_FROM_NEXT;
        end else if (CNT_W'(i + 1) == count_q) begin
          cell_op[i] = CELL_FROM_HEAD;
        end
      end
      if (do_pop && CNT_W'(i) >= CNT_W'(position_i) && CNT_W'(i + 1) < count_q) begin
        cell_op[i] = CELL_FROM_NEXT;
      end
      if (do_swap) begin
        if (IDX_W'(i) == scan_q) begin
          cell_op[i] = CELL_FROM_PREV;
        end else if (CNT_W'(i + 1) == CNT_W'(scan_q)) begin
          cell_op[i] = CELL_FROM_NEXT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] next_w, prev_w;
    if (g < DEPTH - 1) begin : g_next
      assign next_w = entry[g+1];
    end else begin : g_tail
      assign next_w = '0;
    end
    if (g > 0) begin : g_prev
      assign prev_w = entry[g-1];
    end else begin : g_head
      assign prev_w = '0;
    end
    vrpts_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .value_i (cell_value),
      .next_i  (next_w),
      .prev_i  (prev_w),
      .head_i  (entry[0]),
      .entry_o (entry[g]),
      .match_o (match[g])
    );
  end

  vrpts_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .steps_i   (steps_i),
    .divisor_i (count_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q   <= rot_d;
    scan_q  <= scan_d;
    value_q <= value_d;
    if (res_load) begin
      status_q    <= res_status;
      data_q      <= res_data;
      found_q     <= res_found;
      out_count_q <= res_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_o        = data_q;
  assign found_index_o = found_q;
  assign count_o       = out_count_q;

endmodule

// File: hdl/vrpts_cell.sv
// ----------------------------------------------------------------------------
// vrpts_cell
// One entry of the vector: loads from the input value, a neighbour or the head entry.
// ----------------------------------------------------------------------------
module vrpts_cell (
  input  logic                                clk_i,
  input  vrpts_pkg::cell_op_e                 op_i,
  input  logic signed [vrpts_pkg::DATA_W-1:0] value_i,
  input  logic signed [vrpts_pkg::DATA_W-1:0] next_i,
  input  logic signed [vrpts_pkg::DATA_W-1:0] prev_i,
  input  logic signed [vrpts_pkg::DATA_W-1:0] head_i,
  output logic signed [vrpts_pkg::DATA_W-1:0] entry_o,
  output logic                                match_o
);
  import vrpts_pkg::*;

  logic signed [DATA_W-1:0] entry_d, entry_q;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:      entry_d = entry_q;
      CELL_LOAD:      entry_d = value_i;
      CELL_FROM_NEXT: entry_d = next_i;
      CELL_FROM_PREV: entry_d = prev_i;
      CELL_FROM_HEAD: entry_d = head_i;
      default:        entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == value_i);

endmodule

// File: hdl/vrpts_mod_unit.sv
// ----------------------------------------------------------------------------
// vrpts_mod_unit
// Restoring remainder of the rotation amount by the entry count, one bit a cycle.
// ----------------------------------------------------------------------------
module vrpts_mod_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [vrpts_pkg::STEPS_W-1:0]      steps_i,
  input  logic [vrpts_pkg::CNT_W-1:0]        divisor_i,
  output logic                               done_o,
  output logic [vrpts_pkg::IDX_W-1:0]        rem_o
);
  import vrpts_pkg::*;

  localparam int unsigned BIT_W = $clog2(STEPS_W);

  logic               busy_d, busy_q;
  logic               done_d, done_q;
  logic [BIT_W-1:0]   bit_d, bit_q;
  logic [STEPS_W-1:0] steps_d, steps_q;
  logic [IDX_W-1:0]   rem_d, rem_q;
  logic [CNT_W-1:0]   trial;

  // The remainder stays below the divisor, so the shifted trial fits CNT_W bits.
  assign trial = {rem_q, steps_q[STEPS_W-1]};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    bit_d   = bit_q;
    steps_d = steps_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      bit_d   = BIT_W'(STEPS_W - 1);
      steps_d = steps_i;
      rem_d   = '0;
    end else if (busy_q) begin
      steps_d = steps_q << 1;
      if (trial >= divisor_i) begin
        rem_d = IDX_W'(trial - divisor_i);
      end else begin
        rem_d = IDX_W'(trial);
      end
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q   <= bit_d;
    steps_q <= steps_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector rotate, pop and search block. A local
// model of the vector predicts every result at the input transfer, and each
// output transfer is compared in order against the oldest prediction. Both
// channels idle at random until the last stretch of traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import vrpts_pkg::*;

  typedef struct packed {
    status_e                     status;
    logic signed [DATA_W-1:0]    data;
    logic signed [FOUND_W-1:0]   found_index;
    logic [CNT_W-1:0]            count;
  } vec_result_t;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 60;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [ACT_W-1:0]           action_i = '0;
  logic signed [DATA_W-1:0]   value_i = '0;
  logic [POS_W-1:0]           position_i = '0;
  logic [STEPS_W-1:0]         steps_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [STAT_W-1:0]          status_o;
  logic signed [DATA_W-1:0]   data_o;
  logic signed [FOUND_W-1:0]  found_index_o;
  logic [CNT_W-1:0]           count_o;

  logic signed [DATA_W-1:0]   model_entries [DEPTH];
  int                         model_count = 0;
  vec_result_t                pending_results [$];
  int                         error_count = 0;
  bit                         no_idle = 1'b0;

  vector_rotate_pop_transpose_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .steps_i       (steps_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .data_o        (data_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one operation to the local copy of the vector and returns the
  // result that the block should report for it.
  function automatic vec_result_t apply_vector_op(input logic [ACT_W-1:0] act,
                                                  input logic signed [DATA_W-1:0] val,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [STEPS_W-1:0] stp);
    vec_result_t res;
    logic signed [DATA_W-1:0] rotated [DEPTH];
    logic signed [DATA_W-1:0] held;
    int shift;
    int dst;
    bit hit;
    res.status = STAT_OK;
    res.data = '0;
    res.found_index = FOUND_NONE;
    case (act)
      ACT_APPEND: begin
        if (model_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          model_entries[model_count] = val;
          model_count++;
        end
      end
      ACT_ROT_RIGHT: begin
        if (model_count > 1) begin
          shift = int'(stp) % model_count;
          for (int i = 0; i < model_count; i++) begin
            dst = i + shift;
            if (dst >= model_count) dst -= model_count;
            rotated[dst] = model_entries[i];
          end
          for (int i = 0; i < model_count; i++) model_entries[i] = rotated[i];
        end
      end
      ACT_ROT_LEFT: begin
        if (model_count > 1) begin
          held = model_entries[0];
          for (int i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
          model_entries[model_count-1] = held;
        end
      end
      ACT_POP: begin
        if (int'(pos) >= model_count) begin
          res.status = STAT_BAD;
        end else begin
          res.data = model_entries[pos];
          for (int i = int'(pos); i + 1 < model_count; i++) begin
            model_entries[i] = model_entries[i+1];
          end
          model_count--;
        end
      end
      ACT_SEARCH: begin
        res.status = STAT_MISS;
        hit = 1'b0;
        for (int i = 0; i < model_count; i++) begin
          if (!hit && model_entries[i] == val) begin
            hit = 1'b1;
            res.status = STAT_OK;
            if (i == 0) begin
              res.found_index = '0;
            end else begin
              held = model_entries[i];
              model_entries[i] = model_entries[i-1];
              model_entries[i-1] = held;
              res.found_index = FOUND_W'(i - 1);
            end
          end
        end
      end
      default: res.status = STAT_BAD;
    endcase
    res.count = CNT_W'(model_count);
    return res;
  endfunction

  // Drives one item and holds it until the transfer; valid stays high on
  // return so that back-to-back items need no gap.
  task automatic send_op(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
                         input logic [POS_W-1:0] pos, input logic [STEPS_W-1:0] stp);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    position_i <= pos;
    steps_i    <= stp;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_vector_op(act, val, pos, stp));
  endtask

  // Small values are favoured so that duplicates turn up in searches.
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 6)) - 3;
      4:          return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] search_value();
    if (model_count > 0 && $urandom_range(0, 99) < 65) begin
      return model_entries[$urandom_range(0, model_count - 1)];
    end
    return random_value();
  endfunction

  function automatic logic [POS_W-1:0] pop_position();
    if (model_count > 0 && $urandom_range(0, 99) < 80) begin
      return POS_W'($urandom_range(0, model_count - 1));
    end
    return POS_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [STEPS_W-1:0] random_steps();
    return $urandom_range(0, 1) ? STEPS_W'($urandom_range(0, 2 * DEPTH))
                                : STEPS_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_random_op(input mix_e mix);
    int r;
    int append_w;
    int pop_w;
    logic [ACT_W-1:0] act;
    logic signed [DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    append_w = (mix == MIX_FILL) ? 50 : (mix == MIX_DRAIN) ? 10 : 25;
    pop_w    = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 50 : 20;
    if (r < append_w) act = ACT_APPEND;
    else if (r < append_w + pop_w) act = ACT_POP;
    else if (r < append_w + pop_w + 12) act = ACT_ROT_RIGHT;
    else if (r < append_w + pop_w + 22) act = ACT_ROT_LEFT;
    else if (r < 97) act = ACT_SEARCH;
    else act = ACT_W'($urandom_range(5, 7));
    val = (act == ACT_SEARCH) ? search_value() : random_value();
    send_op(act, val, pop_position(), random_steps());
  endtask

  task automatic test_empty_vector();
    send_op(ACT_POP, 32'sd7, 5'd0, 16'd0);
    send_op(ACT_POP, -32'sd1, 5'd31, 16'hFFFF);
    send_op(ACT_ROT_RIGHT, 32'sd0, 5'd0, 16'hFFFF);
    send_op(ACT_ROT_LEFT, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_SEARCH, 32'sd0, 5'd0, 16'd0);
    send_op(3'd5, 32'sd1, 5'd1, 16'd1);
    send_op(3'd6, 32'sd2, 5'd2, 16'd2);
    send_op(3'd7, -32'sd1, 5'd31, 16'hFFFF);
  endtask

  task automatic test_edge_values();
    send_op(ACT_APPEND, 32'sh8000_0000, 5'd0, 16'd0);
    // A single entry must stay put under either rotation.
    send_op(ACT_ROT_RIGHT, 32'sd0, 5'd0, 16'hFFFF);
    send_op(ACT_ROT_LEFT, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_APPEND, 32'sh7FFF_FFFF, 5'd31, 16'hFFFF);
    send_op(ACT_APPEND, -32'sd1, 5'd0, 16'd0);
    send_op(ACT_APPEND, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_SEARCH, 32'sh8000_0000, 5'd0, 16'd0);
    send_op(ACT_SEARCH, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_SEARCH, 32'sd12345, 5'd0, 16'd0);
    // A step count equal to the count wraps round to no movement.
    send_op(ACT_ROT_RIGHT, 32'sd0, 5'd0, 16'd4);
    send_op(ACT_ROT_RIGHT, 32'sd0, 5'd0, 16'hFFFF);
    send_op(ACT_ROT_LEFT, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_POP, 32'sd0, 5'd31, 16'd0);
    send_op(ACT_POP, 32'sd0, 5'd3, 16'd0);
    send_op(ACT_POP, 32'sd0, 5'd0, 16'd0);
  endtask

  task automatic test_full_vector();
    while (model_count < DEPTH) begin
      send_op(ACT_APPEND, random_value(), POS_W'($urandom_range(0, 31)),
              STEPS_W'($urandom_range(0, 65535)));
    end
    send_op(ACT_APPEND, random_value(), 5'd0, 16'd0);
    send_op(ACT_SEARCH, model_entries[DEPTH-1], 5'd0, 16'd0);
    send_op(ACT_ROT_RIGHT, 32'sd0, 5'd0, random_steps());
    send_op(ACT_ROT_LEFT, 32'sd0, 5'd0, 16'd0);
    send_op(ACT_POP, 32'sd0, 5'd31, 16'd0);
    send_op(ACT_APPEND, random_value(), 5'd0, 16'd0);
  endtask

  task automatic test_random_mixed();
    mix_e mix;
    int left_in_mix;
    mix = MIX_BALANCED;
    left_in_mix = 0;
    for (int n = 0; n < 1100; n++) begin
      if (left_in_mix == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        left_in_mix = $urandom_range(30, 90);
      end
      send_random_op(mix);
      left_in_mix--;
    end
  endtask

  // Full-rate traffic on both sides to close the run.
  task automatic test_random_streaming();
    no_idle = 1'b1;
    for (int n = 0; n < 200; n++) begin
      send_random_op(mix_e'($urandom_range(0, 2)));
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    vec_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, status %0d data %0d index %0d count %0d",
                 $time, status_o, data_o, found_index_o, count_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || data_o !== want.data ||
            found_index_o !== want.found_index || count_o !== want.count) begin
          $display("%0t ns: mismatch, expected status %0d data %0d index %0d count %0d",
                   $time, want.status, want.data, want.found_index, want.count);
          $display("%0t ns: mismatch, actual   status %0d data %0d index %0d count %0d",
                   $time, status_o, data_o, found_index_o, count_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_vector();
    test_edge_values();
    test_full_vector();
    test_random_mixed();
    test_random_streaming();
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("%0t ns: run timed out", $time);
    $display("simulation failed");
    $finish;
  end

endmodule
